FILE: src/pascal_like_token_scanner_macros.svh
// Assertion macros for the token scanner.
// Used by plts_queue to check its own fill level and pushes.
`ifndef PASCAL_LIKE_TOKEN_SCANNER_MACROS_SVH
`define PASCAL_LIKE_TOKEN_SCANNER_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle.
`define PLTS_ASSERT_IMP(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);
// Assert that a condition implies a consequence in the next cycle.
`define PLTS_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);
`endif

FILE: src/plts_pkg.sv
// Package for the token scanner: token kinds, status codes, result type.
// No dependencies.
package plts_pkg;
    localparam int IDENT_MAX_LEN_DEF  = 32;
    localparam int STRING_MAX_LEN_DEF = 128;
    localparam int KEYWORD_COUNT      = 7;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [4:0] TK_KEYWORD = 5'd0;
    localparam logic [4:0] TK_IDENT   = 5'd1;
    localparam logic [4:0] TK_INTEGER = 5'd2;
    localparam logic [4:0] TK_STRING  = 5'd3;
    localparam logic [4:0] TK_COMMA   = 5'd4;
    localparam logic [4:0] TK_SEMI    = 5'd5;
    localparam logic [4:0] TK_PERIOD  = 5'd6;
    localparam logic [4:0] TK_COLON   = 5'd7;
    localparam logic [4:0] TK_LPAREN  = 5'd8;
    localparam logic [4:0] TK_RPAREN  = 5'd9;
    localparam logic [4:0] TK_LT      = 5'd10;
    localparam logic [4:0] TK_GT      = 5'd11;
    localparam logic [4:0] TK_EQ      = 5'd12;
    localparam logic [4:0] TK_PLUS    = 5'd13;
    localparam logic [4:0] TK_MINUS   = 5'd14;
    localparam logic [4:0] TK_STAR    = 5'd15;
    localparam logic [4:0] TK_SLASH   = 5'd16;
    localparam logic [4:0] TK_LE      = 5'd17;
    localparam logic [4:0] TK_GE      = 5'd18;
    localparam logic [4:0] TK_NE      = 5'd19;
    localparam logic [4:0] TK_ASSIGN  = 5'd20;

    localparam logic [2:0] ST_TOKEN   = 3'd0;
    localparam logic [2:0] ST_END     = 3'd1;
    localparam logic [2:0] ST_BIGNUM  = 3'd2;
    localparam logic [2:0] ST_LONGSTR = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    localparam logic [2:0] KW_FIN = 3'd3;
    localparam logic [31:0] BIG_NUMBER = 32'h8000_0000;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [2:0]  keyword_index;
        logic [30:0] number_value;
        logic [7:0]  token_length;
        logic [15:0] line_number;
        logic [2:0]  status;
        logic        last_of_run;
    } result_t;

    // Keyword character at a position, upper case; 0 past the end.
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] p);
        logic [71:0] s;
        logic [3:0]  n;
        s = '0;
        n = 4'd0;
        case (k)
            3'd0: begin s[71:32] = "CONST";     n = 4'd5; end
            3'd1: begin s[71:32] = "DEBUT";     n = 4'd5; end
            3'd2: begin s[71:24] = "ECRIRE";    n = 4'd6; end
            3'd3: begin s[71:48] = "FIN";       n = 4'd3; end
            3'd4: begin s[71:40] = "LIRE";      n = 4'd4; end
            3'd5: begin s              = "PROGRAMME"; n = 4'd9; end
            3'd6: begin s[71:48] = "VAR";       n = 4'd3; end
            default: begin s = '0; n = 4'd0; end
        endcase
        if (p >= n)
            return 8'd0;
        return s[71 - 8 * p -: 8];
    endfunction

    function automatic logic [3:0] kw_len(input logic [2:0] k);
        case (k)
            3'd0, 3'd1: return 4'd5;
            3'd2:       return 4'd6;
            3'd3, 3'd6: return 4'd3;
            3'd4:       return 4'd4;
            3'd5:       return 4'd9;
            default:    return 4'd0;
        endcase
    endfunction
endpackage

FILE: src/plts_stream_if.sv
// Valid/ready channel interface carrying a parameterized payload.
// Depends on nothing; payload types come from plts_pkg at instantiation.
interface plts_stream_if #(parameter type payload_t = logic [8:0]);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/plts_front.sv
// Front part: holds the scan state, classifies each byte and produces up to
// two result descriptors per byte. Depends on plts_pkg.
module plts_front #(
    parameter int IDENT_MAX_LEN  = plts_pkg::IDENT_MAX_LEN_DEF,
    parameter int STRING_MAX_LEN = plts_pkg::STRING_MAX_LEN_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic [7:0]           char_code,
    input  logic                 end_of_input,
    output logic [1:0]           res_count,
    output plts_pkg::result_t    res0,
    output plts_pkg::result_t    res1
);
    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_NUMBER, M_STRING, M_STRQ, M_IDENT, M_LT, M_GT, M_COLON
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [7:0]  depth_reg, depth_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  len_reg, len_next;
    logic [6:0]  cand_reg, cand_next;
    logic [15:0] line_reg, line_next;
    logic        halted_reg, halted_next;

    plts_pkg::result_t r0, r1;
    logic [1:0] cnt;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    always_comb
    begin
        plts_pkg::result_t e;
        logic again;
        logic [35:0] prod;
        logic [7:0] up;
        logic found;
        logic [1:0] first_cnt;
        e = '0;
        again = 1'b0;
        prod = '0;
        up = 8'd0;
        found = 1'b0;
        first_cnt = 2'd0;
        mode_next = mode_reg;
        depth_next = depth_reg;
        acc_next = acc_reg;
        len_next = len_reg;
        cand_next = cand_reg;
        line_next = line_reg;
        halted_next = halted_reg;
        cnt = 2'd0;
        r0 = '0;
        r1 = '0;
        if (!halted_reg) begin
            if (!end_of_input && char_code == 8'h0a && line_reg != 16'hffff)
                line_next = line_reg + 16'd1;
            e.line_number = end_of_input ? line_reg : line_next;

            // First phase: the pending token
            e.token_kind = plts_pkg::TK_KEYWORD;
            if (end_of_input || mode_reg == M_IDLE) again = 1'b1;
            unique case (mode_reg)
                M_IDLE: ;
                M_COMMENT:
                begin
                    if (end_of_input) mode_next = M_IDLE;
                    else if (char_code == "{") begin
                        if (depth_reg != 8'hff) depth_next = depth_reg + 8'd1;
                    end else if (char_code == "}") begin
                        if (depth_reg != 8'd0) depth_next = depth_reg - 8'd1;
                        if (depth_reg <= 8'd1) mode_next = M_IDLE;
                    end
                end
                M_NUMBER:
                begin
                    if (!end_of_input && is_digit(char_code)) begin
                        prod = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0}
                             + {28'd0, char_code - 8'h30};
                        acc_next = (prod > 36'd2147483647) ? plts_pkg::BIG_NUMBER
                                                           : prod[31:0];
                    end else begin
                        again = 1'b1;
                        mode_next = M_IDLE;
                        cnt = 2'd1;
                        if (acc_reg[31]) begin
                            r0.status = plts_pkg::ST_BIGNUM;
                            r0.line_number = e.line_number;
                            halted_next = 1'b1;
                        end else begin
                            r0 = e;
                            r0.token_kind = plts_pkg::TK_INTEGER;
                            r0.number_value = acc_reg[30:0];
                        end
                    end
                end
                M_STRING:
                begin
                    if (end_of_input) mode_next = M_IDLE;
                    else if (char_code == "'") mode_next = M_STRQ;
                    else if (32'(len_reg) + 32'd3 >= 32'(STRING_MAX_LEN)) begin
                        cnt = 2'd1;
                        r0.status = plts_pkg::ST_LONGSTR;
                        r0.line_number = e.line_number;
                        halted_next = 1'b1;
                    end else len_next = len_reg + 8'd1;
                end
                M_STRQ:
                begin
                    if (!end_of_input && char_code == "'") begin
                        mode_next = M_STRING;
                        if (32'(len_reg) + 32'd3 >= 32'(STRING_MAX_LEN)) begin
                            cnt = 2'd1;
                            r0.status = plts_pkg::ST_LONGSTR;
                            r0.line_number = e.line_number;
                            halted_next = 1'b1;
                        end else len_next = len_reg + 8'd1;
                    end else begin
                        again = 1'b1;
                        mode_next = M_IDLE;
                        cnt = 2'd1;
                        r0 = e;
                        r0.token_kind = plts_pkg::TK_STRING;
                        r0.token_length = len_reg;
                    end
                end
                M_IDENT:
                begin
                    if (!end_of_input && (is_letter(char_code) || is_digit(char_code)
                                          || char_code == "_")) begin
                        if (32'(len_reg) < 32'(IDENT_MAX_LEN)) begin
                            up = (char_code >= "a" && char_code <= "z")
                               ? char_code - 8'd32 : char_code;
                            for (int k = 0; k < 7; k++)
                                if (len_reg >= 8'(plts_pkg::kw_len(3'(k))) ||
                                    plts_pkg::kw_char(3'(k), len_reg[3:0]) != up)
                                    cand_next[k] = 1'b0;
                            len_next = len_reg + 8'd1;
                        end
                    end else begin
                        again = 1'b1;
                        mode_next = M_IDLE;
                        cnt = 2'd1;
                        r0 = e;
                        r0.token_kind = plts_pkg::TK_IDENT;
                        r0.token_length = len_reg;
                        for (int k = 6; k >= 0; k--)
                            if (cand_reg[k] && len_reg == 8'(plts_pkg::kw_len(3'(k)))) begin
                                found = 1'b1;
                                r0.keyword_index = 3'(k);
                            end
                        if (found) begin
                            r0.token_kind = plts_pkg::TK_KEYWORD;
                            r0.token_length = 8'd0;
                            if (r0.keyword_index == plts_pkg::KW_FIN) halted_next = 1'b1;
                        end
                    end
                end
                M_LT, M_GT, M_COLON:
                begin
                    mode_next = M_IDLE;
                    cnt = 2'd1;
                    r0 = e;
                    if (!end_of_input && char_code == "=")
                        r0.token_kind = (mode_reg == M_LT) ? plts_pkg::TK_LE :
                                        (mode_reg == M_GT) ? plts_pkg::TK_GE :
                                        plts_pkg::TK_ASSIGN;
                    else if (!end_of_input && char_code == ">" && mode_reg == M_LT)
                        r0.token_kind = plts_pkg::TK_NE;
                    else begin
                        again = 1'b1;
                        r0.token_kind = (mode_reg == M_LT) ? plts_pkg::TK_LT :
                                        (mode_reg == M_GT) ? plts_pkg::TK_GT :
                                        plts_pkg::TK_COLON;
                    end
                end
                default: ;
            endcase
            first_cnt = cnt;

            // Second phase: end marker or rescan from idle
            if (again && !halted_next) begin
                r1 = e;
                if (end_of_input) begin
                    mode_next = M_IDLE;
                    r1.status = plts_pkg::ST_END;
                    halted_next = 1'b1;
                    cnt = cnt + 2'd1;
                end else begin
                    mode_next = M_IDLE;
                    case (char_code)
                        " ", 8'h09, 8'h0a: ;
                        "{": begin mode_next = M_COMMENT; depth_next = 8'd1; end
                        "'": begin mode_next = M_STRING; len_next = 8'd0; end
                        "<": mode_next = M_LT;
                        ">": mode_next = M_GT;
                        ":": mode_next = M_COLON;
                        ",": begin r1.token_kind = plts_pkg::TK_COMMA;  cnt = cnt + 2'd1; end
                        ";": begin r1.token_kind = plts_pkg::TK_SEMI;   cnt = cnt + 2'd1; end
                        ".": begin r1.token_kind = plts_pkg::TK_PERIOD; cnt = cnt + 2'd1; end
                        "(": begin r1.token_kind = plts_pkg::TK_LPAREN; cnt = cnt + 2'd1; end
                        ")": begin r1.token_kind = plts_pkg::TK_RPAREN; cnt = cnt + 2'd1; end
                        "=": begin r1.token_kind = plts_pkg::TK_EQ;     cnt = cnt + 2'd1; end
                        "+": begin r1.token_kind = plts_pkg::TK_PLUS;   cnt = cnt + 2'd1; end
                        "-": begin r1.token_kind = plts_pkg::TK_MINUS;  cnt = cnt + 2'd1; end
                        "*": begin r1.token_kind = plts_pkg::TK_STAR;   cnt = cnt + 2'd1; end
                        "/": begin r1.token_kind = plts_pkg::TK_SLASH;  cnt = cnt + 2'd1; end
                        default:
                        begin
                            if (is_digit(char_code)) begin
                                mode_next = M_NUMBER;
                                acc_next = {24'd0, char_code - 8'h30};
                            end else if (is_letter(char_code) || char_code == "_") begin
                                mode_next = M_IDENT;
                                len_next = 8'd1;
                                up = (char_code >= "a" && char_code <= "z")
                                   ? char_code - 8'd32 : char_code;
                                for (int k = 0; k < 7; k++)
                                    cand_next[k] = (plts_pkg::kw_char(3'(k), 4'd0) == up);
                            end else begin
                                r1.status = plts_pkg::ST_UNKNOWN;
                                halted_next = 1'b1;
                                cnt = cnt + 2'd1;
                            end
                        end
                    endcase
                end
            end
            // Pack: if the first phase gave nothing, move the second into slot 0
            if (cnt == 2'd1 && first_cnt == 2'd0)
                r0 = r1;
        end
        res0 = r0;
        res1 = r1;
        res_count = cnt;
        if (cnt == 2'd1) res0.last_of_run = 1'b1;
        if (cnt == 2'd2) res1.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= M_IDLE;
            depth_reg  <= '0;
            acc_reg    <= '0;
            len_reg    <= '0;
            cand_reg   <= '1;
            line_reg   <= '0;
            halted_reg <= 1'b0;
        end else if (in_fire) begin
            mode_reg   <= mode_next;
            depth_reg  <= depth_next;
            acc_reg    <= acc_next;
            len_reg    <= len_next;
            cand_reg   <= cand_next;
            line_reg   <= line_next;
            halted_reg <= halted_next;
        end
    end
endmodule

FILE: src/plts_queue.sv
// Result queue between the scanning front and the output side; takes up
// to two results per cycle and hands out one. Depends on plts_pkg.
`include "pascal_like_token_scanner_macros.svh"
module plts_queue #(
    parameter int DEPTH = plts_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_count,
    input  plts_pkg::result_t push0,
    input  plts_pkg::result_t push1,
    output logic              has_room,
    plts_stream_if.source     out
);
    localparam int AW = $clog2(DEPTH);

    plts_pkg::result_t mem [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   fill_reg, fill_next;
    logic          pop;

    assign pop = out.valid && out.ready;
    assign out.valid = fill_reg != '0;
    assign out.data = mem[rd_reg];
    assign has_room = fill_reg <= (AW + 1)'(DEPTH - 2);
    assign fill_next = fill_reg + (AW + 1)'(push_count) - (AW + 1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0) mem[wr_reg] <= push0;
        if (push_count == 2'd2) mem[wr_reg + AW'(1)] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg <= '0;
            rd_reg <= '0;
            fill_reg <= '0;
        end else begin
            wr_reg <= wr_reg + AW'(push_count);
            rd_reg <= rd_reg + AW'(pop);
            fill_reg <= fill_next;
        end
    end

    `PLTS_ASSERT_IMP(a_no_overflow, push_count != 2'd0, has_room, "queue push while full")
    `PLTS_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= (AW + 1)'(DEPTH), "queue fill exceeds depth")
    `PLTS_ASSERT_NEXT(a_fill_track, push_count == 2'd0 && !pop, $stable(fill_reg),
                      "queue fill moved without transfer")
endmodule

FILE: src/pascal_like_token_scanner.sv
// Token scanner top level: one source byte per transfer in, token
// descriptors out. A byte transfer's results are registered in the result
// queue; throughput 1 byte per cycle while the 4-entry result queue has room
// for two results. Reset (rst_n, async, active low) clears scan state and
// queue. Depends on plts_pkg, plts_stream_if, plts_front and plts_queue.
module pascal_like_token_scanner #(
    parameter int IDENT_MAX_LEN  = plts_pkg::IDENT_MAX_LEN_DEF,
    parameter int STRING_MAX_LEN = plts_pkg::STRING_MAX_LEN_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    plts_stream_if.sink   in_ch,
    plts_stream_if.source out_ch
);
    logic [1:0] cnt;
    plts_pkg::result_t r0, r1;
    logic room, fire;

    assign in_ch.ready = room;
    assign fire = in_ch.valid && room;

    plts_front #(.IDENT_MAX_LEN(IDENT_MAX_LEN), .STRING_MAX_LEN(STRING_MAX_LEN)) u_front (
        .clk(clk), .rst_n(rst_n), .in_fire(fire),
        .char_code(in_ch.data[7:0]), .end_of_input(in_ch.data[8]),
        .res_count(cnt), .res0(r0), .res1(r1)
    );

    plts_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push_count(fire ? cnt : 2'd0),
        .push0(r0), .push1(r1), .has_room(room), .out(out_ch)
    );
endmodule
